@@ rtl/lcdq_pkg.sv @@
package lcdq_pkg;

  localparam int unsigned KindW  = 2;
  localparam int unsigned BytesW = 64;
  localparam int unsigned LenW   = 4;
  localparam int unsigned DelayW = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned AddrW  = 7;
  localparam int unsigned CtrlW  = 8;
  localparam int unsigned LevelW = 5;

  localparam logic [CtrlW-1:0] CtrlCmd  = 8'h00;
  localparam logic [CtrlW-1:0] CtrlData = 8'h40;

  typedef enum logic [KindW-1:0] {
    OP_CMD   = 2'd0,
    OP_DATA  = 2'd1,
    OP_DELAY = 2'd2,
    OP_TICK  = 2'd3
  } op_kind_e;

  // one queued display operation
  typedef struct packed {
    op_kind_e            kind;
    logic [BytesW-1:0]   bytes;
    logic [LenW-1:0]     length;
    logic [DelayW-1:0]   delay;
  } queue_entry_t;

endpackage

@@ rtl/lcdq_store.sv @@
module lcdq_store import lcdq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] waddr_i,
  input  queue_entry_t                   wdata_i,
  input  logic                           re_i,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] raddr_i,
  output queue_entry_t                   rdata_o
);

  queue_entry_t mem_q [QUEUE_DEPTH];
  queue_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/lcd_op_queue_dispatcher_unit.sv @@
// Display operation queue with bus framing. Enqueue transactions (command, data,
// delay) write the operation ring unless it is full and give their result in the
// output register at once. A tick transaction first reads the head entry from
// the single-port-read queue memory, whose registered output arrives in the
// next cycle; then the delay check and dispatch decision are made.
// Only one transaction is in flight at a time; the next one is taken no earlier
// than the edge at which the previous result leaves the output register.
// Configuration writes to the device address take effect on the next frame.
module lcd_op_queue_dispatcher_unit import lcdq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH     = 16,
  parameter int unsigned MAX_FRAME_BYTES = 9
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic [AddrW-1:0]    cfg_wdata_i,

  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [KindW-1:0]    kind_i,
  input  logic [BytesW-1:0]   payload_i,
  input  logic [LenW-1:0]     length_i,
  input  logic [DelayW-1:0]   wait_ms_i,
  input  logic [TimeW-1:0]    now_ms_i,
  input  logic                bus_idle_i,
  input  logic                bus_accepts_i,

  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                accepted_o,
  output logic                frame_valid_o,
  output logic [AddrW-1:0]    frame_address_o,
  output logic [CtrlW-1:0]    control_byte_o,
  output logic [BytesW-1:0]   frame_data_o,
  output logic [LenW-1:0]     frame_length_o,
  output logic                idle_o,
  output logic [LevelW-1:0]   queue_level_o
);

  localparam int unsigned PtrW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MaxData = MAX_FRAME_BYTES - 1;
  localparam int unsigned NBytes  = BytesW / 8;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [PtrW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              pending_q, pending_d;
  logic [TimeW-1:0]  end_time_q, end_time_d;
  logic [AddrW-1:0]  dev_addr_q;

  logic [TimeW-1:0]  now_q, now_d;
  logic              bus_idle_q, bus_idle_d;
  logic              bus_acc_q, bus_acc_d;

  logic              out_valid_q, out_valid_d;
  logic              accepted_q, accepted_d;
  logic              frame_valid_q, frame_valid_d;
  logic [AddrW-1:0]  frame_address_q, frame_address_d;
  logic [CtrlW-1:0]  control_byte_q, control_byte_d;
  logic [BytesW-1:0] frame_data_q, frame_data_d;
  logic [LenW-1:0]   frame_length_q, frame_length_d;
  logic              idle_q, idle_d;
  logic [LevelW-1:0] level_q, level_d;

  logic              in_fire;
  logic              mem_we, mem_re;
  queue_entry_t      wentry, rentry;
  logic [LenW-1:0]   data_len;
  logic [BytesW-1:0] data_bytes;
  logic [TimeW-1:0]  since_end;
  logic              full;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(QUEUE_DEPTH));
  assign mem_re     = in_fire && (op_kind_e'(kind_i) == OP_TICK);

  // saturate the data length and zero the bytes beyond it
  assign data_len = (length_i > LenW'(MaxData)) ? LenW'(MaxData) : length_i;
  always_comb begin
    for (int i = 0; i < NBytes; i++) begin
      data_bytes[i*8 +: 8] = (i < int'(data_len)) ? payload_i[i*8 +: 8] : 8'h00;
    end
  end

  always_comb begin
    wentry.kind   = op_kind_e'(kind_i);
    wentry.bytes  = '0;
    wentry.length = '0;
    wentry.delay  = '0;
    unique case (op_kind_e'(kind_i))
      OP_CMD: begin
        wentry.bytes  = BytesW'(payload_i[7:0]);
        wentry.length = LenW'(1);
      end
      OP_DATA: begin
        wentry.bytes  = data_bytes;
        wentry.length = data_len;
      end
      OP_DELAY: begin
        wentry.delay = wait_ms_i;
      end
      OP_TICK: begin
        wentry.kind = OP_TICK;
      end
      default: begin
        wentry.kind = OP_TICK;
      end
    endcase
  end

  lcdq_store #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (tail_q),
    .wdata_i (wentry),
    .re_i    (mem_re),
    .raddr_i (head_q),
    .rdata_o (rentry)
  );

  assign since_end = now_q - end_time_q;

  always_comb begin
    state_d         = state_q;
    head_d          = head_q;
    tail_d          = tail_q;
    count_d         = count_q;
    pending_d       = pending_q;
    end_time_d      = end_time_q;
    now_d           = now_q;
    bus_idle_d      = bus_idle_q;
    bus_acc_d       = bus_acc_q;
    mem_we          = 1'b0;
    out_valid_d     = out_valid_q && !out_ready_i;
    accepted_d      = accepted_q;
    frame_valid_d   = frame_valid_q;
    frame_address_d = frame_address_q;
    control_byte_d  = control_byte_q;
    frame_data_d    = frame_data_q;
    frame_length_d  = frame_length_q;
    idle_d          = idle_q;
    level_d         = level_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (op_kind_e'(kind_i) == OP_TICK) begin
            now_d      = now_ms_i;
            bus_idle_d = bus_idle_i;
            bus_acc_d  = bus_accepts_i;
            state_d    = S_EXEC;
          end else begin
            if (!full) begin
              mem_we  = 1'b1;
              tail_d  = ptr_inc(tail_q);
              count_d = count_q + 1'b1;
            end
            out_valid_d     = 1'b1;
            accepted_d      = !full;
            frame_valid_d   = 1'b0;
            frame_address_d = '0;
            control_byte_d  = '0;
            frame_data_d    = '0;
            frame_length_d  = '0;
            idle_d          = !pending_q && (count_d == '0) && bus_idle_i;
            level_d         = LevelW'(count_d);
          end
        end
      end
      S_EXEC: begin
        accepted_d      = 1'b0;
        frame_valid_d   = 1'b0;
        frame_address_d = '0;
        control_byte_d  = '0;
        frame_data_d    = '0;
        frame_length_d  = '0;
        // a delay still running blocks dispatch for this tick
        if (!pending_q || !since_end[TimeW-1]) begin
          pending_d = 1'b0;
          if ((count_q != '0) && bus_idle_q) begin
            if (rentry.kind == OP_DELAY) begin
              pending_d  = 1'b1;
              end_time_d = now_q + TimeW'(rentry.delay);
              head_d     = ptr_inc(head_q);
              count_d    = count_q - 1'b1;
            end else if (bus_acc_q) begin
              frame_valid_d   = 1'b1;
              frame_address_d = dev_addr_q;
              control_byte_d  = (rentry.kind == OP_CMD) ? CtrlCmd : CtrlData;
              frame_data_d    = rentry.bytes;
              frame_length_d  = rentry.length;
              head_d          = ptr_inc(head_q);
              count_d         = count_q - 1'b1;
            end
          end
        end
        idle_d      = !pending_d && (count_d == '0) && bus_idle_q;
        level_d     = LevelW'(count_d);
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      pending_q   <= 1'b0;
      end_time_q  <= '0;
      dev_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      pending_q   <= pending_d;
      end_time_q  <= end_time_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        dev_addr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    now_q           <= now_d;
    bus_idle_q      <= bus_idle_d;
    bus_acc_q       <= bus_acc_d;
    accepted_q      <= accepted_d;
    frame_valid_q   <= frame_valid_d;
    frame_address_q <= frame_address_d;
    control_byte_q  <= control_byte_d;
    frame_data_q    <= frame_data_d;
    frame_length_q  <= frame_length_d;
    idle_q          <= idle_d;
    level_q         <= level_d;
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = accepted_q;
  assign frame_valid_o   = frame_valid_q;
  assign frame_address_o = frame_address_q;
  assign control_byte_o  = control_byte_q;
  assign frame_data_o    = frame_data_q;
  assign frame_length_o  = frame_length_q;
  assign idle_o          = idle_q;
  assign queue_level_o   = level_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == tail_q))
    else $error("empty queue with head and tail apart");

  a_exec_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> !out_valid_q)
    else $error("tick result would overwrite a pending result");

  a_frame_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_valid_o) |-> (frame_length_o <= LenW'(MaxData)))
    else $error("frame longer than allowed");

  a_tick_one_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |=> (count_q == $past(count_q)) ||
                            (count_q == $past(count_q) - 1'b1))
    else $error("tick changed the queue by more than one entry");
`endif

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import lcdq_pkg::*;

  localparam int unsigned QDepth     = 16;
  localparam int unsigned MaxData    = 8;
  localparam int unsigned HoldCycles = 64;
  localparam int unsigned QuietLimit = 1000;

  typedef struct packed {
    op_kind_e          kind;
    logic [BytesW-1:0] payload;
    logic [LenW-1:0]   length;
    logic [DelayW-1:0] wait_ms;
    logic [TimeW-1:0]  now_ms;
    logic              bus_idle;
    logic              bus_accepts;
  } op_item_t;

  typedef struct packed {
    logic              accepted;
    logic              frame_valid;
    logic [AddrW-1:0]  frame_address;
    logic [CtrlW-1:0]  control_byte;
    logic [BytesW-1:0] frame_data;
    logic [LenW-1:0]   frame_length;
    logic              idle;
    logic [LevelW-1:0] queue_level;
  } frame_result_t;

  // mirror of the operation ring, delay timer and framing
  class frame_scoreboard;
    op_kind_e          slot_kind  [QDepth];
    logic [BytesW-1:0] slot_bytes [QDepth];
    logic [LenW-1:0]   slot_len   [QDepth];
    logic [DelayW-1:0] slot_delay [QDepth];
    int unsigned       head, tail, count;
    bit                delay_armed;
    logic [TimeW-1:0]  delay_end;
    logic [AddrW-1:0]  dev_addr;
    frame_result_t     expected_frames[$];
    int unsigned       errors, checked, frames_sent, enq_dropped, delays_armed;

    function new();
      head = 0;
      tail = 0;
      count = 0;
      delay_armed = 1'b0;
      delay_end = '0;
      dev_addr = '0;
    endfunction

    function bit push_op(op_kind_e k, logic [BytesW-1:0] b, logic [LenW-1:0] n,
                         logic [DelayW-1:0] d);
      if (count >= QDepth) begin
        enq_dropped++;
        return 1'b0;
      end
      slot_kind[tail]  = k;
      slot_bytes[tail] = b;
      slot_len[tail]   = n;
      slot_delay[tail] = d;
      tail = (tail + 1) % QDepth;
      count++;
      return 1'b1;
    endfunction

    function void drop_head();
      head = (head + 1) % QDepth;
      count--;
    endfunction

    function void take_op(op_item_t it);
      frame_result_t     r;
      int unsigned       n;
      logic [BytesW-1:0] keep;
      logic [TimeW-1:0]  diff;
      bit                go;
      r = '0;
      case (it.kind)
        OP_CMD: r.accepted = push_op(OP_CMD, {56'd0, it.payload[7:0]}, 4'd1, '0);
        OP_DATA: begin
          n = (it.length < MaxData) ? it.length : MaxData;
          keep = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
          r.accepted = push_op(OP_DATA, it.payload & keep, n[LenW-1:0], '0);
        end
        OP_DELAY: r.accepted = push_op(OP_DELAY, '0, '0, it.wait_ms);
        default: begin
          go = 1'b1;
          if (delay_armed) begin
            // wrapping time: expired once now - end is not negative
            diff = it.now_ms - delay_end;
            if (diff[TimeW-1]) go = 1'b0;
            else delay_armed = 1'b0;
          end
          if (go && count > 0 && it.bus_idle) begin
            if (slot_kind[head] == OP_DELAY) begin
              delay_armed = 1'b1;
              delay_end = it.now_ms + TimeW'(slot_delay[head]);
              delays_armed++;
              drop_head();
            end else if (it.bus_accepts) begin
              r.frame_valid   = 1'b1;
              r.frame_address = dev_addr;
              r.control_byte  = (slot_kind[head] == OP_CMD) ? CtrlCmd : CtrlData;
              r.frame_data    = slot_bytes[head];
              r.frame_length  = slot_len[head];
              frames_sent++;
              drop_head();
            end
          end
        end
      endcase
      r.idle = !delay_armed && count == 0 && it.bus_idle;
      r.queue_level = count[LevelW-1:0];
      expected_frames.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_frame(frame_result_t got);
      frame_result_t want;
      if (expected_frames.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
        return;
      end
      want = expected_frames.pop_front();
      checked++;
      compare_field("accepted", want.accepted, got.accepted);
      compare_field("frame_valid", want.frame_valid, got.frame_valid);
      compare_field("frame_address", want.frame_address, got.frame_address);
      compare_field("control_byte", want.control_byte, got.control_byte);
      compare_field("frame_data", want.frame_data, got.frame_data);
      compare_field("frame_length", want.frame_length, got.frame_length);
      compare_field("idle", want.idle, got.idle);
      compare_field("queue_level", want.queue_level, got.queue_level);
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [AddrW-1:0]  cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [KindW-1:0]  kind_i = '0;
  logic [BytesW-1:0] payload_i = '0;
  logic [LenW-1:0]   length_i = '0;
  logic [DelayW-1:0] wait_ms_i = '0;
  logic [TimeW-1:0]  now_ms_i = '0;
  logic              bus_idle_i = 1'b0;
  logic              bus_accepts_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              accepted_o;
  logic              frame_valid_o;
  logic [AddrW-1:0]  frame_address_o;
  logic [CtrlW-1:0]  control_byte_o;
  logic [BytesW-1:0] frame_data_o;
  logic [LenW-1:0]   frame_length_o;
  logic              idle_o;
  logic [LevelW-1:0] queue_level_o;

  frame_scoreboard   sb = new();
  bit                gaps_on = 1'b1;
  bit                hold_req = 1'b0;
  logic [TimeW-1:0]  cur_ms = '0;

  lcd_op_queue_dispatcher_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .payload_i       (payload_i),
    .length_i        (length_i),
    .wait_ms_i       (wait_ms_i),
    .now_ms_i        (now_ms_i),
    .bus_idle_i      (bus_idle_i),
    .bus_accepts_i   (bus_accepts_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .accepted_o      (accepted_o),
    .frame_valid_o   (frame_valid_o),
    .frame_address_o (frame_address_o),
    .control_byte_o  (control_byte_o),
    .frame_data_o    (frame_data_o),
    .frame_length_o  (frame_length_o),
    .idle_o          (idle_o),
    .queue_level_o   (queue_level_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // results are checked before inputs are noted; a result never belongs to
  // a transaction taken at the same edge
  always @(posedge clk_i) begin : monitor
    frame_result_t got;
    op_item_t      seen;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.accepted      = accepted_o;
        got.frame_valid   = frame_valid_o;
        got.frame_address = frame_address_o;
        got.control_byte  = control_byte_o;
        got.frame_data    = frame_data_o;
        got.frame_length  = frame_length_o;
        got.idle          = idle_o;
        got.queue_level   = queue_level_o;
        sb.check_frame(got);
      end
      if (in_valid_i && in_ready_o) begin
        seen.kind        = op_kind_e'(kind_i);
        seen.payload     = payload_i;
        seen.length      = length_i;
        seen.wait_ms     = wait_ms_i;
        seen.now_ms      = now_ms_i;
        seen.bus_idle    = bus_idle_i;
        seen.bus_accepts = bus_accepts_i;
        sb.take_op(seen);
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int unsigned stall;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end
      stall = gaps_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no transaction for %0d cycles", QuietLimit);
    $display("Mismatches found");
    $finish;
  end

  task automatic send_op(input op_item_t it);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= it.kind;
    payload_i     <= it.payload;
    length_i      <= it.length;
    wait_ms_i     <= it.wait_ms;
    now_ms_i      <= it.now_ms;
    bus_idle_i    <= it.bus_idle;
    bus_accepts_i <= it.bus_accepts;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // drain everything outstanding before touching the address register
  task automatic drain();
    in_valid_i <= 1'b0;
    // let the monitor note the last accepted transaction first
    @(posedge clk_i);
    while (sb.expected_frames.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_address(input logic [AddrW-1:0] addr);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= addr;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.dev_addr = addr;
  endtask

  function automatic op_item_t mk(op_kind_e k, logic [BytesW-1:0] p, logic [LenW-1:0] n,
                                  logic [DelayW-1:0] d, logic [TimeW-1:0] t,
                                  logic bi, logic ba);
    op_item_t it;
    it.kind = k;
    it.payload = p;
    it.length = n;
    it.wait_ms = d;
    it.now_ms = t;
    it.bus_idle = bi;
    it.bus_accepts = ba;
    return it;
  endfunction

  function automatic op_item_t rand_op(bit enq_only);
    op_item_t    it;
    int unsigned r;
    it.payload = {$urandom, $urandom};
    it.length = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(0, 8));
    r = $urandom_range(0, 9);
    it.wait_ms = (r == 0) ? 16'($urandom) : (r < 3) ? 16'd0 : 16'($urandom_range(1, 12));
    it.now_ms = $urandom;
    it.bus_idle = ($urandom_range(0, 4) != 0);
    it.bus_accepts = ($urandom_range(0, 3) != 0);
    if (enq_only || $urandom_range(0, 99) < 40) begin
      it.kind = op_kind_e'($urandom_range(0, 2));
    end else begin
      it.kind = OP_TICK;
      r = $urandom_range(0, 99);
      // mostly steady time, now and then a jump forward or anywhere
      if (r < 3) cur_ms = $urandom;
      else if (r < 6) cur_ms += 32'd70000;
      else cur_ms += $urandom_range(0, 5);
      it.now_ms = cur_ms;
    end
    return it;
  endfunction

  task automatic run_random(input int unsigned n, input bit with_hold);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 50 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      if (with_hold && i == n / 2) hold_req = 1'b1;
      if (i % 60 == 30) begin
        // enqueue burst drives the ring to full
        for (int unsigned b = 0; b < 18; b++) send_op(rand_op(1'b1));
      end else begin
        send_op(rand_op(1'b0));
      end
    end
  endtask

  initial begin : stimulus
    logic [TimeW-1:0] t0;
    logic [AddrW-1:0] addr;
    t0 = 32'hFFFF_FFF0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_address(7'h7F);

    send_op(mk(OP_TICK, '0, '0, '0, '0, 1'b1, 1'b1));
    send_op(mk(OP_TICK, '1, '1, '1, '1, 1'b0, 1'b0));
    send_op(mk(OP_CMD, '1, '1, '1, '1, 1'b1, 1'b1));
    send_op(mk(OP_DATA, 64'h0123_4567_89AB_CDEF, 4'd0, '0, '0, 1'b1, 1'b1));
    send_op(mk(OP_DATA, '1, 4'd8, '0, '0, 1'b1, 1'b1));
    send_op(mk(OP_DATA, 64'hA5A5_5A5A_C3C3_3C3C, 4'd15, '0, '0, 1'b1, 1'b1));
    send_op(mk(OP_DATA, {$urandom, $urandom}, 4'd3, '0, '0, 1'b1, 1'b1));
    send_op(mk(OP_DELAY, '0, '0, 16'd0, '0, 1'b1, 1'b1));
    send_op(mk(OP_DELAY, '0, '0, 16'hFFFF, '0, 1'b1, 1'b1));
    send_op(mk(OP_CMD, 64'h38, '0, '0, '0, 1'b1, 1'b1));
    send_op(mk(OP_TICK, '0, '0, '0, t0, 1'b0, 1'b1));
    send_op(mk(OP_TICK, '0, '0, '0, t0, 1'b1, 1'b0));
    repeat (5) send_op(mk(OP_TICK, '0, '0, '0, t0, 1'b1, 1'b1));
    // zero delay arms, expires later and the long one arms; it then ends
    // exactly one tick past the last still-running time, across the wrap
    send_op(mk(OP_TICK, '0, '0, '0, t0, 1'b1, 1'b1));
    send_op(mk(OP_TICK, '0, '0, '0, t0 + 32'd100, 1'b1, 1'b1));
    send_op(mk(OP_TICK, '0, '0, '0, t0 + 32'd65634, 1'b1, 1'b1));
    send_op(mk(OP_TICK, '0, '0, '0, t0 + 32'd65635, 1'b1, 1'b1));
    send_op(mk(OP_TICK, '0, '0, '0, t0 + 32'd65636, 1'b1, 1'b1));

    for (int unsigned p = 0; p < 4; p++) begin
      drain();
      addr = (p == 0) ? 7'h00 : (p == 1) ? 7'h7F : 7'($urandom);
      write_address(addr);
      if (p == 2) cur_ms = 32'hFFFF_FF80;
      run_random(130, p == 1);
    end
    drain();
    repeat (8) @(posedge clk_i);

    $display("checked %0d results: %0d frames sent, %0d delays armed", sb.checked,
             sb.frames_sent, sb.delays_armed);
    $display("%0d enqueues dropped on a full ring, four address settings", sb.enq_dropped);
    if (sb.errors == 0 && sb.expected_frames.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ lcd_op_queue_dispatcher_unit.f @@
rtl/lcdq_pkg.sv
rtl/lcdq_store.sv
rtl/lcd_op_queue_dispatcher_unit.sv
test/tb_top.sv
